### rtl/i2cmts_pkg.sv
// ============================================================================
// i2cmts_pkg: shared types and constants of the I2C master sequencer.
// Command, action and status codes, the input item and the decision record.
// ============================================================================
package i2cmts_pkg;

    typedef enum logic [2:0] {
        CMD_STATUS     = 3'd0,
        CMD_BEGIN_RD   = 3'd1,
        CMD_BEGIN_WR   = 3'd2,
        CMD_BEGIN_WRRD = 3'd3,
        CMD_STOP       = 3'd4,
        CMD_LOAD       = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        ACT_NONE         = 4'd0,
        ACT_START        = 4'd1,
        ACT_STOP         = 4'd2,
        ACT_SEND         = 4'd3,
        ACT_ACK          = 4'd4,
        ACT_NACK         = 4'd5,
        ACT_CLEAR        = 4'd6,
        ACT_RECOVER      = 4'd7,
        ACT_STOP_RECOVER = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        DONE_OK        = 2'd0,
        DONE_ADDR_NACK = 2'd1,
        DONE_DATA_NACK = 2'd2
    } t_done;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_RECV = 4'b0010,
        PH_SEND = 4'b0100,
        PH_WRRD = 4'b1000
    } t_phase;

    // Bus controller status codes, low three bits masked off.
    localparam logic [7:0] ST_MASK         = 8'hF8;
    localparam logic [7:0] ST_NONE         = 8'h00;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_TX_ADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_TX_ADDR_NACK = 8'h20;
    localparam logic [7:0] ST_TX_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_TX_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_RX_ADDR_ACK  = 8'h40;
    localparam logic [7:0] ST_RX_ADDR_NACK = 8'h48;
    localparam logic [7:0] ST_RX_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_RX_DATA_NACK = 8'h58;

    localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
    localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] status_code;
        logic [7:0] read_data;
        logic [7:0] bus_address;
        logic [7:0] byte_count;
        logic [5:0] prefix_count;
        logic [4:0] store_index;
        logic [7:0] store_value;
    } t_item;

    // One decision; the store byte is filled in from the RAM in the cycle after.
    typedef struct packed {
        t_action    action;
        logic       send_valid;
        logic       send_from_store;
        logic [7:0] send_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       done_valid;
        t_done      done_status;
        logic       busy;
        logic       refused;
    } t_dec;

endpackage

### rtl/i2cmts_ram.sv
// ============================================================================
// i2cmts_ram: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle.
// ============================================================================
module i2cmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/i2cmts_ctrl.sv
// ============================================================================
// i2cmts_ctrl: transaction state and per-item decision.
// Holds the phase and counters, decides one action per item, drives the store.
// ============================================================================
module i2cmts_ctrl #(
    parameter int STORE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  i2cmts_pkg::t_item              i_item,
    output i2cmts_pkg::t_dec               o_dec,
    output logic                           o_ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_waddr,
    output logic [7:0]                     o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_raddr
);

    localparam int SPW = $clog2(STORE_DEPTH);
    localparam logic [SPW-1:0] PTR_LAST = SPW'(STORE_DEPTH - 1);

    i2cmts_pkg::t_phase r_phase, n_phase;
    logic [7:0]     r_target, n_target;
    logic [7:0]     r_read_rem, n_read_rem;
    logic [7:0]     r_write_rem, n_write_rem;
    logic [5:0]     r_prefix_rem, n_prefix_rem;
    logic [SPW-1:0] r_send_ptr, n_send_ptr;
    logic [7:0]     r_recv_ptr, n_recv_ptr;

    i2cmts_pkg::t_dec dec;
    logic [7:0]       st;
    logic             busy;
    logic             take_store;
    logic             data_nack;

    assign st   = i_item.status_code & i2cmts_pkg::ST_MASK;
    assign busy = (r_phase != i2cmts_pkg::PH_IDLE);

    always_comb begin
        n_phase      = r_phase;
        n_target     = r_target;
        n_read_rem   = r_read_rem;
        n_write_rem  = r_write_rem;
        n_prefix_rem = r_prefix_rem;
        n_send_ptr   = r_send_ptr;
        n_recv_ptr   = r_recv_ptr;
        take_store   = 1'b0;
        data_nack    = 1'b0;
        dec          = '0;
        dec.action      = i2cmts_pkg::ACT_NONE;
        dec.done_status = i2cmts_pkg::DONE_OK;

        unique case (i_item.command)
            i2cmts_pkg::CMD_BEGIN_RD, i2cmts_pkg::CMD_BEGIN_WR,
            i2cmts_pkg::CMD_BEGIN_WRRD: begin
                if (busy) begin
                    dec.refused = 1'b1;
                end else begin
                    n_send_ptr = '0;
                    n_recv_ptr = '0;
                    dec.action = i2cmts_pkg::ACT_START;
                    if (i_item.command == i2cmts_pkg::CMD_BEGIN_RD) begin
                        n_target   = i_item.bus_address | i2cmts_pkg::ADDR_RD_BIT;
                        n_read_rem = i_item.byte_count;
                        n_phase    = i2cmts_pkg::PH_RECV;
                    end else if (i_item.command == i2cmts_pkg::CMD_BEGIN_WR) begin
                        n_target    = i_item.bus_address;
                        n_write_rem = i_item.byte_count;
                        n_phase     = i2cmts_pkg::PH_SEND;
                    end else begin
                        n_target     = i_item.bus_address & i2cmts_pkg::ADDR_WR_MASK;
                        n_read_rem   = i_item.byte_count;
                        n_prefix_rem = i_item.prefix_count;
                        n_phase      = i2cmts_pkg::PH_WRRD;
                    end
                end
            end
            i2cmts_pkg::CMD_STOP: begin
                dec.action = i2cmts_pkg::ACT_STOP_RECOVER;
                n_phase    = i2cmts_pkg::PH_IDLE;
            end
            i2cmts_pkg::CMD_LOAD: begin
                // Store writes are handled on the RAM port below.
            end
            i2cmts_pkg::CMD_STATUS: begin
                unique case (st)
                    i2cmts_pkg::ST_START: begin
                        dec.send_byte  = r_target;
                        dec.send_valid = 1'b1;
                        dec.action     = i2cmts_pkg::ACT_SEND;
                    end
                    i2cmts_pkg::ST_RX_ADDR_ACK: begin
                        dec.action = (r_read_rem > 8'd1) ? i2cmts_pkg::ACT_ACK
                                                         : i2cmts_pkg::ACT_NACK;
                    end
                    i2cmts_pkg::ST_RX_ADDR_NACK, i2cmts_pkg::ST_TX_ADDR_NACK: begin
                        dec.action      = i2cmts_pkg::ACT_STOP;
                        n_phase         = i2cmts_pkg::PH_IDLE;
                        dec.done_valid  = 1'b1;
                        dec.done_status = i2cmts_pkg::DONE_ADDR_NACK;
                    end
                    i2cmts_pkg::ST_RX_DATA_ACK: begin
                        n_read_rem   = r_read_rem - 8'd1;
                        dec.rx_byte  = i_item.read_data;
                        dec.rx_index = r_recv_ptr;
                        dec.rx_valid = 1'b1;
                        n_recv_ptr   = r_recv_ptr + 8'd1;
                        dec.action   = (n_read_rem > 8'd1) ? i2cmts_pkg::ACT_ACK
                                                           : i2cmts_pkg::ACT_NACK;
                    end
                    i2cmts_pkg::ST_RX_DATA_NACK: begin
                        dec.rx_byte    = i_item.read_data;
                        dec.rx_index   = r_recv_ptr;
                        dec.rx_valid   = 1'b1;
                        dec.action     = i2cmts_pkg::ACT_STOP;
                        n_phase        = i2cmts_pkg::PH_IDLE;
                        dec.done_valid = 1'b1;
                    end
                    i2cmts_pkg::ST_TX_ADDR_ACK, i2cmts_pkg::ST_TX_DATA_ACK: begin
                        if (r_phase == i2cmts_pkg::PH_SEND) begin
                            if (r_write_rem != 8'd0) begin
                                n_write_rem = r_write_rem - 8'd1;
                                take_store  = 1'b1;
                            end else begin
                                dec.action     = i2cmts_pkg::ACT_STOP;
                                n_phase        = i2cmts_pkg::PH_IDLE;
                                dec.done_valid = 1'b1;
                            end
                        end else if (r_phase == i2cmts_pkg::PH_WRRD) begin
                            if (r_prefix_rem != 6'd0) begin
                                n_prefix_rem = r_prefix_rem - 6'd1;
                                take_store   = 1'b1;
                            end else begin
                                dec.action = i2cmts_pkg::ACT_START;
                            end
                        end else if (st == i2cmts_pkg::ST_TX_DATA_ACK) begin
                            data_nack = 1'b1;
                        end
                    end
                    i2cmts_pkg::ST_TX_DATA_NACK: begin
                        data_nack = 1'b1;
                    end
                    i2cmts_pkg::ST_RESTART: begin
                        if (r_phase == i2cmts_pkg::PH_WRRD) begin
                            n_phase        = i2cmts_pkg::PH_RECV;
                            n_target       = r_target | i2cmts_pkg::ADDR_RD_BIT;
                            dec.send_byte  = n_target;
                            dec.send_valid = 1'b1;
                            dec.action     = i2cmts_pkg::ACT_SEND;
                        end else begin
                            n_phase    = i2cmts_pkg::PH_IDLE;
                            dec.action = i2cmts_pkg::ACT_STOP;
                        end
                    end
                    i2cmts_pkg::ST_NONE: begin
                        dec.action = i2cmts_pkg::ACT_CLEAR;
                    end
                    default: begin
                        dec.action = i2cmts_pkg::ACT_RECOVER;
                        n_phase    = i2cmts_pkg::PH_IDLE;
                    end
                endcase
                if (take_store) begin
                    dec.send_valid      = 1'b1;
                    dec.send_from_store = 1'b1;
                    dec.action          = i2cmts_pkg::ACT_SEND;
                    n_send_ptr = (r_send_ptr == PTR_LAST) ? '0 : r_send_ptr + 1'b1;
                end
                if (data_nack) begin
                    dec.action      = i2cmts_pkg::ACT_STOP;
                    n_phase         = i2cmts_pkg::PH_IDLE;
                    dec.done_valid  = 1'b1;
                    dec.done_status = i2cmts_pkg::DONE_DATA_NACK;
                end
            end
            default: begin
                // Unused command codes leave everything as it is.
            end
        endcase
        dec.busy = (n_phase != i2cmts_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cmts_pkg::PH_IDLE;
            r_target     <= '0;
            r_read_rem   <= '0;
            r_write_rem  <= '0;
            r_prefix_rem <= '0;
            r_send_ptr   <= '0;
            r_recv_ptr   <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_target     <= n_target;
            r_read_rem   <= n_read_rem;
            r_write_rem  <= n_write_rem;
            r_prefix_rem <= n_prefix_rem;
            r_send_ptr   <= n_send_ptr;
            r_recv_ptr   <= n_recv_ptr;
        end
    end

    assign o_dec       = dec;
    assign o_ram_we    = i_accept && (i_item.command == i2cmts_pkg::CMD_LOAD)
                         && (32'(i_item.store_index) < STORE_DEPTH);
    assign o_ram_waddr = SPW'(i_item.store_index);
    assign o_ram_wdata = i_item.store_value;
    assign o_ram_re    = i_accept && take_store;
    assign o_ram_raddr = r_send_ptr;

endmodule

### rtl/i2c_master_transaction_sequencer_top.sv
// ============================================================================
// I2C master transaction sequencer: accepts one transfer per cycle while the
// pipeline has room or the result channel takes results; each result passes
// through stage one, which waits for the send store read, and then the output
// register. Synchronous reset returns to idle with empty pipeline; send store contents are not cleared.
// ============================================================================
module i2c_master_transaction_sequencer_top #(
    parameter int STORE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata from bit 0: status_code[7:0], read_data[15:8], bus_address[23:16],
    // byte_count[31:24], prefix_count[37:32], store_index[42:38],
    // store_value[50:43], zero fill[55:51].
    input  logic [55:0] i_s_axis_tdata,
    // tuser: command[2:0].
    input  logic [2:0]  i_s_axis_tuser,
    // Result channel.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata from bit 0: send_byte[7:0], send_valid[8], rx_byte[16:9],
    // rx_index[24:17], rx_valid[25], done_valid[26], done_status[28:27],
    // busy_res[29], start_refused[30], zero fill[31].
    output logic [31:0] o_m_axis_tdata,
    // tuser: bus_action[3:0].
    output logic [3:0]  o_m_axis_tuser
);

    localparam int SPW = $clog2(STORE_DEPTH);

    // The decision is made and the transaction state updated in the cycle an
    // input transfer is accepted; a store read is launched at the same time.
    // Stage one holds the decision while the RAM answers, then the result is
    // assembled into the output register. Stage one only advances when the
    // output register is empty or being drained, and the RAM read data only
    // changes on a new accept, so a stalled result keeps its store byte.

    i2cmts_pkg::t_item item;
    i2cmts_pkg::t_dec  dec;
    logic              accept;
    logic              s1_adv;

    logic              ram_we;
    logic [SPW-1:0]    ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [SPW-1:0]    ram_raddr;
    logic [7:0]        ram_rdata;

    logic              r_s1_valid;
    i2cmts_pkg::t_dec  r_s1_dec;
    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic [3:0]        r_out_user;
    logic [7:0]        send_byte;

    assign item.command      = i2cmts_pkg::t_cmd'(i_s_axis_tuser);
    assign item.status_code  = i_s_axis_tdata[7:0];
    assign item.read_data    = i_s_axis_tdata[15:8];
    assign item.bus_address  = i_s_axis_tdata[23:16];
    assign item.byte_count   = i_s_axis_tdata[31:24];
    assign item.prefix_count = i_s_axis_tdata[37:32];
    assign item.store_index  = i_s_axis_tdata[42:38];
    assign item.store_value  = i_s_axis_tdata[50:43];

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    i2cmts_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .o_dec       (dec),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    // Send store: filled by load commands, read once per data byte sent.
    i2cmts_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Stage one: decision waiting for the store byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_dec <= dec;
        end
    end

    assign send_byte = r_s1_dec.send_from_store ? ram_rdata : r_s1_dec.send_byte;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {1'b0, r_s1_dec.refused, r_s1_dec.busy,
                           r_s1_dec.done_status, r_s1_dec.done_valid,
                           r_s1_dec.rx_valid, r_s1_dec.rx_index, r_s1_dec.rx_byte,
                           r_s1_dec.send_valid, send_byte};
            r_out_user <= r_s1_dec.action;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

### rtl/i2cmts_checker.sv
// ============================================================================
// i2cmts_checker: port-level checks of the I2C master sequencer.
// Watches the result channel for protocol and consistency slips.
// ============================================================================
module i2cmts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [55:0] i_s_axis_tdata,
    input logic [2:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // A finished transaction leaves the block idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[26] |-> !o_m_axis_tdata[29])
        else $error("completion reported while still busy");

    // A refused begin does nothing and only happens while busy.
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[30] |->
            o_m_axis_tuser == i2cmts_pkg::ACT_NONE && o_m_axis_tdata[29])
        else $error("refused begin with an action or while idle");

    // A byte to send goes with the send action and only with it.
    a_send_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[8] == (o_m_axis_tuser == i2cmts_pkg::ACT_SEND))
        else $error("send flag and action disagree");

    // A received byte goes with an acknowledge decision or the final stop.
    a_rx_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[25] |->
            o_m_axis_tuser == i2cmts_pkg::ACT_ACK ||
            o_m_axis_tuser == i2cmts_pkg::ACT_NACK ||
            o_m_axis_tuser == i2cmts_pkg::ACT_STOP)
        else $error("received byte with an unexpected action");

endmodule

bind i2c_master_transaction_sequencer_top i2cmts_checker u_i2cmts_checker (.*);
